// ===== sv/keyframe_cubic_hermite_interpolator_defines.svh =====
// Assertion macros for the keyframe cubic Hermite interpolator.
// Used by the RTL files that carry concurrent checks.
`ifndef KEYFRAME_CUBIC_HERMITE_INTERPOLATOR_DEFINES_SVH
`define KEYFRAME_CUBIC_HERMITE_INTERPOLATOR_DEFINES_SVH

// Same-cycle implication under active-low reset.
`define KHI_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under active-low reset.
`define KHI_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/khi_pkg.sv =====
// Shared types and constants of the keyframe cubic Hermite interpolator.
// No dependencies.
`timescale 1ns / 1ps
package khi_pkg;

    localparam int  PW         = 36;
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic [23:0] frame;
        logic [31:0] tstamp;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [15:0] pitch;
        logic [15:0] yaw;
        logic [15:0] roll;
        logic [15:0] fov;
    } t_key;

    typedef enum logic [3:0] {
        S_IDLE, S_SRCH, S_LOAD, S_TSET, S_DIV, S_T2, S_T3, S_EVAL, S_OUT
    } t_state;

    typedef enum logic [2:0] {
        PH_IDLE, PH_MB, PH_MC, PH_MD, PH_ACC, PH_OUT
    } t_ph;

    typedef enum logic [2:0] {
        CH_X, CH_Y, CH_Z, CH_PITCH, CH_YAW, CH_ROLL, CH_FOV
    } t_chan;

    localparam int NUM_CH = 7;

    typedef enum logic [1:0] {
        SAT_POS, SAT_ANG, SAT_FOV
    } t_sat;

    typedef struct packed {
        logic start;
        t_sat sat;
    } t_eval_req;

    typedef struct packed {
        logic        done;
        logic [31:0] value;
    } t_eval_rsp;

endpackage

// ===== sv/khi_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module khi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/khi_eval.sv =====
// One-channel Catmull-Rom evaluator: coefficients, shared multiplier,
// accumulate, round and saturate. Depends on khi_pkg.
`timescale 1ns / 1ps
module khi_eval #(
    parameter int T_FRAC_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  khi_pkg::t_eval_req             i_req,
    input  logic signed [khi_pkg::PW-1:0]  i_p0,
    input  logic signed [khi_pkg::PW-1:0]  i_p1,
    input  logic signed [khi_pkg::PW-1:0]  i_p2,
    input  logic signed [khi_pkg::PW-1:0]  i_p3,
    input  logic [T_FRAC_BITS:0]           i_t,
    input  logic [T_FRAC_BITS:0]           i_t2,
    input  logic [T_FRAC_BITS:0]           i_t3,
    output khi_pkg::t_eval_rsp             o_rsp
);

    localparam int TW = T_FRAC_BITS + 1;
    localparam int PW = khi_pkg::PW;
    localparam int MW = PW + TW + 1;
    localparam int AW = PW + TW + 3;

    khi_pkg::t_ph           r_ph, n_ph;
    khi_pkg::t_sat          r_sat;
    logic signed [PW-1:0]   r_b, r_c, r_d;
    logic signed [AW-1:0]   r_acc, r_prod;
    logic                   r_done;
    logic [31:0]            r_val;

    logic signed [PW-1:0]   w_ma;
    logic [TW-1:0]          w_mb;
    logic signed [TW:0]     w_mbs;
    logic signed [MW-1:0]   w_mul;
    logic signed [AW-1:0]   w_sum, w_q, w_hi, w_lo, w_sat;

    always_comb begin
        unique case (r_ph)
            khi_pkg::PH_IDLE: n_ph = i_req.start ? khi_pkg::PH_MB : khi_pkg::PH_IDLE;
            khi_pkg::PH_MB:   n_ph = khi_pkg::PH_MC;
            khi_pkg::PH_MC:   n_ph = khi_pkg::PH_MD;
            khi_pkg::PH_MD:   n_ph = khi_pkg::PH_ACC;
            khi_pkg::PH_ACC:  n_ph = khi_pkg::PH_OUT;
            default:          n_ph = khi_pkg::PH_IDLE;
        endcase
    end

    always_comb begin
        unique case (r_ph)
            khi_pkg::PH_MC: begin
                w_ma = r_c;
                w_mb = i_t2;
            end
            khi_pkg::PH_MD: begin
                w_ma = r_d;
                w_mb = i_t3;
            end
            default: begin
                w_ma = r_b;
                w_mb = i_t;
            end
        endcase
    end

    assign w_mbs = $signed({1'b0, w_mb});
    assign w_mul = w_ma * w_mbs;
    assign w_sum = r_acc + (AW'(1) <<< T_FRAC_BITS);
    assign w_q   = w_sum >>> (T_FRAC_BITS + 1);

    always_comb begin
        case (r_sat)
            khi_pkg::SAT_ANG: begin
                w_hi = AW'(32767);
                w_lo = -AW'(32767) - AW'(1);
            end
            khi_pkg::SAT_FOV: begin
                w_hi = AW'(65535);
                w_lo = '0;
            end
            default: begin
                w_hi = AW'(2147483647);
                w_lo = -AW'(2147483647) - AW'(1);
            end
        endcase
        if (w_q > w_hi) begin
            w_sat = w_hi;
        end else if (w_q < w_lo) begin
            w_sat = w_lo;
        end else begin
            w_sat = w_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= khi_pkg::PH_IDLE;
            r_done <= 1'b0;
        end else begin
            r_ph   <= n_ph;
            r_done <= (r_ph == khi_pkg::PH_OUT);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_ph)
            khi_pkg::PH_IDLE: begin
                if (i_req.start) begin
                    r_sat <= i_req.sat;
                    r_b   <= i_p2 - i_p0;
                    r_c   <= (i_p0 <<< 1) - (i_p1 <<< 2) - i_p1 + (i_p2 <<< 2) - i_p3;
                    r_d   <= (i_p1 <<< 1) + i_p1 - i_p0 - (i_p2 <<< 1) - i_p2 + i_p3;
                    r_acc <= AW'(i_p1) <<< (T_FRAC_BITS + 1);
                end
            end
            khi_pkg::PH_MB: begin
                r_prod <= AW'(w_mul);
            end
            khi_pkg::PH_MC, khi_pkg::PH_MD: begin
                r_acc  <= r_acc + r_prod;
                r_prod <= AW'(w_mul);
            end
            khi_pkg::PH_ACC: begin
                r_acc <= r_acc + r_prod;
            end
            khi_pkg::PH_OUT: begin
                r_val <= w_sat[31:0];
            end
            default: begin
            end
        endcase
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.value = r_val;

endmodule

// ===== sv/keyframe_cubic_hermite_interpolator.sv =====
// Query: the serial table search, the bit-per-cycle divider for t (skipped when t is 0 or 1)
// and seven passes through the shared channel evaluator. Fewer than four keys: the query
// goes straight to the output stage and returns a zero result.
// Keyframe write: one item per cycle while no query is in progress. One query at a time; a held result stalls the next.
// Reset (synchronous, active low) clears control and the count; the keyframe memory is
// undefined until written. Depends on khi_pkg, khi_ram, khi_eval and the assertion header.
`timescale 1ns / 1ps
`include "keyframe_cubic_hermite_interpolator_defines.svh"
module keyframe_cubic_hermite_interpolator #(
    parameter int MAX_KEYS    = 32,
    parameter int T_FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [5:0]         i_cfg_keyframe_count,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_kind,
    input  logic [4:0]         i_slot,
    input  logic [23:0]        i_frame_number,
    input  logic [31:0]        i_time_value,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [15:0] i_pitch,
    input  logic signed [15:0] i_yaw,
    input  logic signed [15:0] i_roll,
    input  logic [15:0]        i_fov,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_valid_res,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [31:0] o_out_z,
    output logic signed [15:0] o_out_pitch,
    output logic signed [15:0] o_out_yaw,
    output logic signed [15:0] o_out_roll,
    output logic [15:0]        o_out_fov
);

    localparam int AW  = $clog2(MAX_KEYS);
    localparam int NW  = $clog2(MAX_KEYS + 1);
    localparam int TW  = T_FRAC_BITS + 1;
    localparam int KW  = $bits(khi_pkg::t_key);
    localparam int PW  = khi_pkg::PW;
    localparam int DCW = $clog2(T_FRAC_BITS + 1);
    localparam logic [TW-1:0]   T_ONE  = {1'b1, {T_FRAC_BITS{1'b0}}};
    localparam logic [2*TW-1:0] T_HALF = (2*TW)'(1) << (T_FRAC_BITS - 1);

    khi_pkg::t_state     r_state, n_state;
    logic [5:0]          r_count;
    logic [23:0]         r_fr;
    logic [31:0]         r_qtime;
    logic                r_short;
    logic [NW-1:0]       r_ra, r_ri;
    logic                r_rv;
    logic [AW-1:0]       r_st;
    logic [2:0]          r_k;
    logic                r_lv;
    logic [1:0]          r_lk;
    khi_pkg::t_key       r_key [4];
    logic [32:0]         r_rem, r_s;
    logic [T_FRAC_BITS-1:0] r_q;
    logic [DCW-1:0]      r_dcnt;
    logic [TW-1:0]       r_t, r_t2, r_t3;
    khi_pkg::t_chan      r_ch;
    logic                r_wait;
    logic [31:0]         r_res [khi_pkg::NUM_CH];
    logic                r_ovalid;

    logic [NW-1:0]       w_n, w_idx, w_back, w_st;
    logic                w_accept, w_we, w_hit, w_last;
    khi_pkg::t_key       w_wkey, w_rdata;
    logic [KW-1:0]       w_rdata_raw;
    logic [AW-1:0]       w_raddr;
    logic signed [32:0]  w_e, w_s;
    logic                w_tzero, w_tone;
    logic [32:0]         w_rem2;
    logic                w_ge;
    logic [T_FRAC_BITS-1:0] w_q;
    logic [2*TW-1:0]     w_mt, w_rnd;
    logic signed [PW-1:0] w_p [4];
    khi_pkg::t_eval_req  w_req;
    khi_pkg::t_eval_rsp  w_rsp;
    logic                w_oload;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == khi_pkg::S_IDLE);
    assign w_accept    = i_valid && o_ready;
    assign w_n = (int'(r_count) > MAX_KEYS) ? NW'(MAX_KEYS) : NW'(r_count);
    assign w_we = w_accept && (i_kind == khi_pkg::KIND_WRITE) && (int'(i_slot) < MAX_KEYS);

    assign w_wkey.frame  = i_frame_number;
    assign w_wkey.tstamp = i_time_value;
    assign w_wkey.x      = i_pos_x;
    assign w_wkey.y      = i_pos_y;
    assign w_wkey.z      = i_pos_z;
    assign w_wkey.pitch  = i_pitch;
    assign w_wkey.yaw    = i_yaw;
    assign w_wkey.roll   = i_roll;
    assign w_wkey.fov    = i_fov;

    khi_ram #(
        .WIDTH (KW),
        .DEPTH (MAX_KEYS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (AW'(i_slot)),
        .i_wdata (w_wkey),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata_raw)
    );

    assign w_rdata = w_rdata_raw;

    // search and window
    assign w_hit  = r_rv && (w_rdata.frame > r_fr);
    assign w_last = r_rv && (r_ri == w_n - NW'(1));
    assign w_idx  = w_hit ? r_ri : w_n;
    assign w_back = (w_idx == w_n) ? NW'(4) : ((w_idx == w_n - NW'(1)) ? NW'(3) : NW'(2));
    assign w_st   = (w_idx >= w_back) ? (w_idx - w_back) : '0;

    // t setup and division
    assign w_e = $signed({1'b0, r_qtime}) - $signed({1'b0, r_key[1].tstamp});
    assign w_s = $signed({1'b0, r_key[2].tstamp}) - $signed({1'b0, r_key[1].tstamp});
    assign w_tzero = w_s[32] || (w_s == '0) || w_e[32] || (w_e == '0);
    assign w_tone  = (w_e >= w_s);
    assign w_rem2  = {r_rem[31:0], 1'b0};
    assign w_ge    = (w_rem2 >= r_s);
    assign w_q     = {r_q[T_FRAC_BITS-2:0], w_ge};
    assign w_mt    = r_t * ((r_state == khi_pkg::S_T3) ? r_t2 : r_t);
    assign w_rnd   = (w_mt + T_HALF) >> T_FRAC_BITS;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            case (r_ch)
                khi_pkg::CH_X:     w_p[k] = PW'($signed(r_key[k].x));
                khi_pkg::CH_Y:     w_p[k] = PW'($signed(r_key[k].y));
                khi_pkg::CH_Z:     w_p[k] = PW'($signed(r_key[k].z));
                khi_pkg::CH_PITCH: w_p[k] = PW'($signed(r_key[k].pitch));
                khi_pkg::CH_YAW:   w_p[k] = PW'($signed(r_key[k].yaw));
                khi_pkg::CH_ROLL:  w_p[k] = PW'($signed(r_key[k].roll));
                default:           w_p[k] = $signed(PW'(r_key[k].fov));
            endcase
        end
    end

    khi_eval #(
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_eval (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_p0    (w_p[0]),
        .i_p1    (w_p[1]),
        .i_p2    (w_p[2]),
        .i_p3    (w_p[3]),
        .i_t     (r_t),
        .i_t2    (r_t2),
        .i_t3    (r_t3),
        .o_rsp   (w_rsp)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            khi_pkg::S_IDLE: begin
                if (w_accept && (i_kind == khi_pkg::KIND_QUERY)) begin
                    n_state = (w_n < NW'(4)) ? khi_pkg::S_OUT : khi_pkg::S_SRCH;
                end
            end
            khi_pkg::S_SRCH: if (w_hit || w_last) n_state = khi_pkg::S_LOAD;
            khi_pkg::S_LOAD: if (r_lv && (r_lk == 2'd3)) n_state = khi_pkg::S_TSET;
            khi_pkg::S_TSET: begin
                n_state = (w_tzero || w_tone) ? khi_pkg::S_T2 : khi_pkg::S_DIV;
            end
            khi_pkg::S_DIV:  if (r_dcnt == DCW'(1)) n_state = khi_pkg::S_T2;
            khi_pkg::S_T2:   n_state = khi_pkg::S_T3;
            khi_pkg::S_T3:   n_state = khi_pkg::S_EVAL;
            khi_pkg::S_EVAL: begin
                if (w_rsp.done && (r_ch == khi_pkg::CH_FOV)) n_state = khi_pkg::S_OUT;
            end
            khi_pkg::S_OUT:  if (w_oload) n_state = khi_pkg::S_IDLE;
            default:         n_state = khi_pkg::S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        w_raddr   = r_ra[AW-1:0];
        w_req.start = 1'b0;
        w_oload   = 1'b0;
        unique case (r_state)
            khi_pkg::S_LOAD: w_raddr = r_st + AW'(r_k[1:0]);
            khi_pkg::S_EVAL: w_req.start = !r_wait;
            khi_pkg::S_OUT:  w_oload = !r_ovalid || i_ready;
            default: begin
            end
        endcase
        case (r_ch)
            khi_pkg::CH_X, khi_pkg::CH_Y, khi_pkg::CH_Z:          w_req.sat = khi_pkg::SAT_POS;
            khi_pkg::CH_PITCH, khi_pkg::CH_YAW, khi_pkg::CH_ROLL: w_req.sat = khi_pkg::SAT_ANG;
            default:                                               w_req.sat = khi_pkg::SAT_FOV;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= khi_pkg::S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_rv     <= 1'b0;
            r_lv     <= 1'b0;
            r_wait   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_count <= i_cfg_keyframe_count;
            end
            if (w_oload) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            r_rv <= (r_state == khi_pkg::S_SRCH) && !(w_hit || w_last) && (r_ra < w_n);
            r_lv <= (r_state == khi_pkg::S_LOAD) && !r_k[2];
            if (r_state == khi_pkg::S_EVAL) begin
                if (w_rsp.done) begin
                    r_wait <= 1'b0;
                end else if (!r_wait) begin
                    r_wait <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            khi_pkg::S_IDLE: begin
                r_fr    <= i_frame_number;
                r_qtime <= i_time_value;
                r_short <= (w_n < NW'(4));
                r_ra    <= '0;
                r_k     <= '0;
                r_ch    <= khi_pkg::CH_X;
            end
            khi_pkg::S_SRCH: begin
                if (r_ra < w_n) r_ra <= r_ra + NW'(1);
                r_ri <= r_ra;
                r_st <= AW'(w_st);
            end
            khi_pkg::S_LOAD: begin
                if (!r_k[2]) r_k <= r_k + 3'd1;
                r_lk <= r_k[1:0];
                if (r_lv) r_key[r_lk] <= w_rdata;
            end
            khi_pkg::S_TSET: begin
                r_rem  <= w_e;
                r_s    <= w_s;
                r_q    <= '0;
                r_dcnt <= DCW'(T_FRAC_BITS);
                r_t    <= w_tzero ? '0 : T_ONE;
            end
            khi_pkg::S_DIV: begin
                r_rem  <= w_ge ? (w_rem2 - r_s) : w_rem2;
                r_q    <= w_q;
                r_dcnt <= r_dcnt - DCW'(1);
                r_t    <= {1'b0, w_q};
            end
            khi_pkg::S_T2: r_t2 <= w_rnd[TW-1:0];
            khi_pkg::S_T3: r_t3 <= w_rnd[TW-1:0];
            khi_pkg::S_EVAL: begin
                if (w_rsp.done) begin
                    r_res[r_ch] <= w_rsp.value;
                    if (r_ch != khi_pkg::CH_FOV) r_ch <= khi_pkg::t_chan'(r_ch + 3'd1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_oload) begin
            o_valid_res <= !r_short;
            o_out_x     <= r_short ? '0 : r_res[khi_pkg::CH_X];
            o_out_y     <= r_short ? '0 : r_res[khi_pkg::CH_Y];
            o_out_z     <= r_short ? '0 : r_res[khi_pkg::CH_Z];
            o_out_pitch <= r_short ? '0 : r_res[khi_pkg::CH_PITCH][15:0];
            o_out_yaw   <= r_short ? '0 : r_res[khi_pkg::CH_YAW][15:0];
            o_out_roll  <= r_short ? '0 : r_res[khi_pkg::CH_ROLL][15:0];
            o_out_fov   <= r_short ? '0 : r_res[khi_pkg::CH_FOV][15:0];
        end
    end

    assign o_valid = r_ovalid;

    `KHI_ASSERT_IMP(a_srch_bound, i_clk, i_rst_n, r_state == khi_pkg::S_SRCH, r_ra <= w_n, "search address past key count")
    `KHI_ASSERT_IMP(a_t_range, i_clk, i_rst_n, r_state == khi_pkg::S_T2, r_t <= T_ONE, "t above one")
    `KHI_ASSERT_NXT(a_short_query, i_clk, i_rst_n, w_accept && (i_kind == khi_pkg::KIND_QUERY) && (w_n < NW'(4)), r_state == khi_pkg::S_OUT, "short query skipped output")

endmodule

// ===== sim/keyframe_cubic_hermite_interpolator_tb.sv =====
// Testbench for keyframe_cubic_hermite_interpolator: random keyframe tables and queries
// are checked against an in-bench Catmull-Rom predictor. Depends on khi_pkg and the RTL.
`timescale 1ns / 1ps
module keyframe_cubic_hermite_interpolator_tb;

    localparam longint ONE = 64'sd65536;

    typedef struct {
        logic               kind;
        logic [4:0]         slot;
        logic [23:0]        frame;
        logic [31:0]        tv;
        logic signed [31:0] x, y, z;
        logic signed [15:0] pitch, yaw, roll;
        logic [15:0]        fov;
    } t_key_item;

    typedef struct {
        logic               vr;
        logic signed [31:0] x, y, z;
        logic signed [15:0] pitch, yaw, roll;
        logic [15:0]        fov;
    } t_pose;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [5:0]         i_cfg_keyframe_count = '0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic               i_kind = 1'b0;
    logic [4:0]         i_slot = '0;
    logic [23:0]        i_frame_number = '0;
    logic [31:0]        i_time_value = '0;
    logic signed [31:0] i_pos_x = '0, i_pos_y = '0, i_pos_z = '0;
    logic signed [15:0] i_pitch = '0, i_yaw = '0, i_roll = '0;
    logic [15:0]        i_fov = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic               o_valid_res;
    logic signed [31:0] o_out_x, o_out_y, o_out_z;
    logic signed [15:0] o_out_pitch, o_out_yaw, o_out_roll;
    logic [15:0]        o_out_fov;

    keyframe_cubic_hermite_interpolator i_dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor state
    logic [5:0]         key_count = '0;
    logic [23:0]        key_frame [32];
    logic [31:0]        key_time [32];
    logic signed [31:0] key_x [32], key_y [32], key_z [32];
    logic signed [15:0] key_pitch [32], key_yaw [32], key_roll [32];
    logic [15:0]        key_fov [32];

    // generator view of the table
    logic [23:0] plan_frame [32];
    logic [31:0] plan_time [32];

    t_key_item pending_items [$];
    t_pose     expected_poses [$];
    int        fail_count = 0;

    function automatic longint sat(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint hermite(longint p0, longint p1, longint p2, longint p3,
                                       longint t, longint t2, longint t3);
        longint b, c, d, s;
        b = p2 - p0;
        c = 2 * p0 - 5 * p1 + 4 * p2 - p3;
        d = -p0 + 3 * p1 - 3 * p2 + p3;
        s = 2 * p1 * ONE + b * t + c * t2 + d * t3;
        return (s + ONE) >>> 17;
    endfunction

    function automatic t_pose predict_pose(t_key_item q);
        t_pose  r;
        int     n, idx, back, st;
        longint e, s, t, t2, t3;
        longint p [7][4];
        longint v [7];
        r = '{default: '0};
        n = key_count > 32 ? 32 : key_count;
        if (n < 4) return r;
        idx = n;
        for (int i = n - 1; i >= 0; i--) if (key_frame[i] > q.frame) idx = i;
        back = (idx == n) ? 4 : ((idx == n - 1) ? 3 : 2);
        st = idx >= back ? idx - back : 0;
        e = longint'({32'd0, q.tv}) - longint'({32'd0, key_time[st + 1]});
        s = longint'({32'd0, key_time[st + 2]}) - longint'({32'd0, key_time[st + 1]});
        if (s <= 0 || e <= 0) t = 0;
        else if (e >= s) t = ONE;
        else t = (e * ONE) / s;
        t2 = (t * t + ONE / 2) >> 16;
        t3 = (t2 * t + ONE / 2) >> 16;
        for (int k = 0; k < 4; k++) begin
            p[0][k] = key_x[st + k];
            p[1][k] = key_y[st + k];
            p[2][k] = key_z[st + k];
            p[3][k] = key_pitch[st + k];
            p[4][k] = key_yaw[st + k];
            p[5][k] = key_roll[st + k];
            p[6][k] = longint'({48'd0, key_fov[st + k]});
        end
        for (int ch = 0; ch < 7; ch++)
            v[ch] = hermite(p[ch][0], p[ch][1], p[ch][2], p[ch][3], t, t2, t3);
        r.vr    = 1'b1;
        r.x     = 32'(sat(v[0], -64'sd2147483648, 64'sd2147483647));
        r.y     = 32'(sat(v[1], -64'sd2147483648, 64'sd2147483647));
        r.z     = 32'(sat(v[2], -64'sd2147483648, 64'sd2147483647));
        r.pitch = 16'(sat(v[3], -32768, 32767));
        r.yaw   = 16'(sat(v[4], -32768, 32767));
        r.roll  = 16'(sat(v[5], -32768, 32767));
        r.fov   = 16'(sat(v[6], 0, 65535));
        return r;
    endfunction

    // driver
    int gap_left = 0;
    int send_burst = 0;
    always @(posedge i_clk) begin
        t_key_item it;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!(i_valid && !o_ready)) begin
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                i_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                it = pending_items.pop_front();
                i_valid <= 1'b1;
                i_kind <= it.kind;
                i_slot <= it.slot;
                i_frame_number <= it.frame;
                i_time_value <= it.tv;
                i_pos_x <= it.x;
                i_pos_y <= it.y;
                i_pos_z <= it.z;
                i_pitch <= it.pitch;
                i_yaw <= it.yaw;
                i_roll <= it.roll;
                i_fov <= it.fov;
                if (send_burst > 0) send_burst = send_burst - 1;
                else if ($urandom_range(0, 15) == 0) send_burst = $urandom_range(10, 40);
                gap_left = send_burst > 0 ? 0 : $urandom_range(0, 11);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor and checker
    int stall_left = 0;
    int recv_burst = 0;
    always @(posedge i_clk) begin
        t_key_item it;
        t_pose     ex;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (expected_poses.size() == 0) begin
                    $error("result with no query outstanding");
                    fail_count++;
                end else begin
                    ex = expected_poses.pop_front();
                    if (o_valid_res !== ex.vr) begin
                        $error("valid_res expected %0d got %0d", ex.vr, o_valid_res);
                        fail_count++;
                    end
                    if (o_out_x !== ex.x) begin
                        $error("out_x expected %0d got %0d", ex.x, o_out_x);
                        fail_count++;
                    end
                    if (o_out_y !== ex.y) begin
                        $error("out_y expected %0d got %0d", ex.y, o_out_y);
                        fail_count++;
                    end
                    if (o_out_z !== ex.z) begin
                        $error("out_z expected %0d got %0d", ex.z, o_out_z);
                        fail_count++;
                    end
                    if (o_out_pitch !== ex.pitch) begin
                        $error("out_pitch expected %0d got %0d", ex.pitch, o_out_pitch);
                        fail_count++;
                    end
                    if (o_out_yaw !== ex.yaw) begin
                        $error("out_yaw expected %0d got %0d", ex.yaw, o_out_yaw);
                        fail_count++;
                    end
                    if (o_out_roll !== ex.roll) begin
                        $error("out_roll expected %0d got %0d", ex.roll, o_out_roll);
                        fail_count++;
                    end
                    if (o_out_fov !== ex.fov) begin
                        $error("out_fov expected %0d got %0d", ex.fov, o_out_fov);
                        fail_count++;
                    end
                end
                if (recv_burst > 0) recv_burst = recv_burst - 1;
                else if ($urandom_range(0, 15) == 0) recv_burst = $urandom_range(10, 40);
                stall_left = recv_burst > 0 ? 0 : $urandom_range(0, 11);
            end
            if (i_valid && o_ready) begin
                it = '{i_kind, i_slot, i_frame_number, i_time_value, i_pos_x, i_pos_y,
                       i_pos_z, i_pitch, i_yaw, i_roll, i_fov};
                if (it.kind == khi_pkg::KIND_WRITE) begin
                    key_frame[it.slot] = it.frame;
                    key_time[it.slot]  = it.tv;
                    key_x[it.slot]     = it.x;
                    key_y[it.slot]     = it.y;
                    key_z[it.slot]     = it.z;
                    key_pitch[it.slot] = it.pitch;
                    key_yaw[it.slot]   = it.yaw;
                    key_roll[it.slot]  = it.roll;
                    key_fov[it.slot]   = it.fov;
                end else begin
                    expected_poses.push_back(predict_pose(it));
                end
            end
            if (stall_left > 0) begin
                stall_left = stall_left - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    function automatic t_key_item make_key(int sl, logic [23:0] fr, logic [31:0] tv,
                                           bit big);
        t_key_item it;
        it.kind  = khi_pkg::KIND_WRITE;
        it.slot  = 5'(sl);
        it.frame = fr;
        it.tv    = tv;
        it.x     = big ? $urandom : $signed($urandom_range(0, 1 << 21)) - (1 << 20);
        it.y     = big ? $urandom : $signed($urandom_range(0, 1 << 21)) - (1 << 20);
        it.z     = big ? $urandom : $signed($urandom_range(0, 1 << 21)) - (1 << 20);
        it.pitch = 16'(big ? $urandom : $signed($urandom_range(0, 8000)) - 4000);
        it.yaw   = 16'(big ? $urandom : $signed($urandom_range(0, 8000)) - 4000);
        it.roll  = 16'(big ? $urandom : $signed($urandom_range(0, 8000)) - 4000);
        it.fov   = 16'(big ? $urandom : $urandom_range(0, 30000));
        plan_frame[sl] = fr;
        plan_time[sl]  = tv;
        return it;
    endfunction

    function automatic t_key_item make_query(logic [23:0] fr, logic [31:0] tv);
        t_key_item it;
        it = '{default: '0};
        it.kind  = khi_pkg::KIND_QUERY;
        it.frame = fr;
        it.tv    = tv;
        it.x     = $urandom;
        it.fov   = 16'($urandom);
        return it;
    endfunction

    task automatic drain();
        while (pending_items.size() > 0 || i_valid || expected_poses.size() > 0)
            @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    task automatic write_count(logic [5:0] cnt);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_keyframe_count <= cnt;
        do @(posedge i_clk); while (!o_cfg_ready);
        key_count = cnt;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic fill_table(bit sorted, bit big);
        logic [23:0] fr;
        logic [31:0] tv;
        fr = 24'($urandom_range(0, 1000));
        tv = $urandom_range(0, 1 << 20);
        for (int sl = 0; sl < 32; sl++) begin
            pending_items.push_back(make_key(sl, sorted ? fr : 24'($urandom), tv, big));
            fr = 24'(fr + $urandom_range(0, 3));
            case ($urandom_range(0, 7))
                0: tv = tv;
                1: tv = tv - $urandom_range(0, 1 << 16);
                default: tv = tv + $urandom_range(1, 1 << 18);
            endcase
        end
    endtask

    task automatic add_queries(int nq);
        int          j;
        logic [23:0] fr;
        logic [31:0] tv;
        for (int q = 0; q < nq; q++) begin
            j = $urandom_range(0, 31);
            case ($urandom_range(0, 9))
                0: fr = 24'h0;
                1: fr = 24'hFFFFFF;
                2: fr = 24'($urandom);
                default: fr = 24'(plan_frame[j] + $urandom_range(0, 2) - 1);
            endcase
            j = $urandom_range(0, 30);
            case ($urandom_range(0, 9))
                0: tv = 32'h0;
                1: tv = 32'hFFFFFFFF;
                2: tv = $urandom;
                default: tv = plan_time[j] + $urandom_range(0, 1 << 18) - (1 << 14);
            endcase
            if ($urandom_range(0, 11) == 0)
                pending_items.push_back(make_key($urandom_range(0, 31), 24'($urandom),
                                                 $urandom, 1'($urandom_range(0, 1))));
            pending_items.push_back(make_query(fr, tv));
        end
    endtask

    initial begin
        logic [5:0] counts [10];
        counts = '{6'd4, 6'd5, 6'd32, 6'd63, 6'd33, 6'd17, 6'd6, 6'd4, 6'd31, 6'd8};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table and too few keys give a zero result
        pending_items.push_back(make_query(24'h0, 32'h0));
        pending_items.push_back(make_query(24'hFFFFFF, 32'hFFFFFFFF));
        drain();
        write_count(6'd3);
        pending_items.push_back(make_query(24'h123, 32'h8000));
        drain();
        write_count(6'd0);
        pending_items.push_back(make_query(24'h5, 32'h5));
        drain();

        // extreme keys: saturation, table ends, zero span
        write_count(6'd63);
        for (int sl = 0; sl < 32; sl++) begin
            pending_items.push_back(make_key(sl, 24'(sl * 2 + 1), 32'(sl < 16 ? sl * 65536 :
                                             32'hFFFFFFFF), 1'b0));
            pending_items[$].x     = sl[0] ? 32'sh7FFFFFFF : 32'sh80000000;
            pending_items[$].pitch = sl[0] ? 16'sh7FFF : 16'sh8000;
            pending_items[$].fov   = sl[0] ? 16'hFFFF : 16'h0000;
        end
        pending_items.push_back(make_query(24'h0, 32'h0));
        pending_items.push_back(make_query(24'hFFFFFF, 32'hFFFFFFFF));
        pending_items.push_back(make_query(24'd61, 32'hFFFFFFFF));
        pending_items.push_back(make_query(24'd20, 32'h000A8000));
        pending_items.push_back(make_query(24'd40, 32'hFFFFFFFF));
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            write_count(counts[ph]);
            fill_table(ph % 4 != 3, ph % 3 == 2);
            add_queries(50);
            drain();
        end

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
